@@ design/cbd_pkg.sv @@
// Shared types, character codes and helpers for the chunked body decoder.
package cbd_pkg;

    // Default width of the chunk-size counter.
    localparam int SIZE_BITS_DEF = 32;

    // Output queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    // Character codes.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SIZE    = 3'd1,
        PH_DATA    = 3'd2,
        PH_DATA_CR = 3'd3,
        PH_DATA_LF = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_message;
        logic       format_error;
    } t_result;

    // Up to two result items produced by one input item.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              full2;
    } t_q_status;

    // True for an ASCII hex digit of either case.
    function automatic logic hex_ok(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // Value of an ASCII hex digit; meaningless for other characters.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

@@ design/cbd_parser.sv @@
// Byte-wide parser: header pass-through, chunk-size lines, data, trailing CRLF.
module cbd_parser import cbd_pkg::*; #(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_first_byte,
    output t_push      o_push
);

    t_phase               r_phase,      n_phase;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                 r_line_text,  n_line_text;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_in_ext,     n_in_ext;

    // Effective state: a first byte restarts the parser before it is processed.
    t_phase               cur_phase;
    logic [SIZE_BITS-1:0] cur_left;
    logic                 cur_text;
    logic                 cur_digit;
    logic                 cur_ext;

    logic                 is_cr;
    logic                 is_lf;
    logic                 is_hex;
    logic                 size_ovf;
    logic [SIZE_BITS-1:0] left_dec;

    always_comb begin
        cur_phase = i_first_byte ? PH_HEADER : r_phase;
        cur_left  = i_first_byte ? '0 : r_bytes_left;
        cur_text  = i_first_byte ? 1'b0 : r_line_text;
        cur_digit = i_first_byte ? 1'b0 : r_digit_seen;
        cur_ext   = i_first_byte ? 1'b0 : r_in_ext;
    end

    // Character classes and counter arithmetic.
    assign is_cr    = (i_in_byte == CH_CR);
    assign is_lf    = (i_in_byte == CH_LF);
    assign is_hex   = hex_ok(i_in_byte);
    assign size_ovf = (cur_left[SIZE_BITS-1 -: 4] != 4'd0);
    assign left_dec = cur_left - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // Next-state logic.
    always_comb begin
        n_phase      = cur_phase;
        n_bytes_left = cur_left;
        n_line_text  = cur_text;
        n_digit_seen = cur_digit;
        n_in_ext     = cur_ext;
        case (cur_phase)
            PH_HEADER: begin
                if (is_lf) begin
                    if (!cur_text) begin
                        n_phase      = PH_SIZE;
                        n_bytes_left = '0;
                        n_digit_seen = 1'b0;
                        n_in_ext     = 1'b0;
                    end
                    n_line_text = 1'b0;
                end else if (!is_cr) begin
                    n_line_text = 1'b1;
                end
            end
            PH_SIZE: begin
                if (is_lf) begin
                    if (!cur_digit) begin
                        n_phase = PH_ERROR;
                    end else if (cur_left == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (is_cr || cur_ext) begin
                    n_phase = PH_SIZE;
                end else if (!is_hex) begin
                    n_in_ext = 1'b1;
                end else if (size_ovf) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_bytes_left = {cur_left[SIZE_BITS-5:0], hex_val(i_in_byte)};
                    n_digit_seen = 1'b1;
                end
            end
            PH_DATA: begin
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = is_cr ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
                if (is_lf) begin
                    n_phase      = PH_SIZE;
                    n_bytes_left = '0;
                    n_digit_seen = 1'b0;
                    n_in_ext     = 1'b0;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    // Result generation.
    always_comb begin
        o_push    = '0;
        o_push.r1 = '{out_byte: CH_LF, end_of_message: 1'b1, format_error: 1'b0};
        case (cur_phase)
            PH_HEADER, PH_DATA: begin
                o_push.count = 2'd1;
                o_push.r0    = '{out_byte: i_in_byte, end_of_message: 1'b0,
                                 format_error: 1'b0};
            end
            PH_SIZE: begin
                if (is_lf && !cur_digit) begin
                    o_push.count = 2'd1;
                    o_push.r0    = '{out_byte: 8'h00, end_of_message: 1'b1,
                                     format_error: 1'b1};
                end else if (is_lf && cur_left == '0) begin
                    o_push.count = 2'd2;
                    o_push.r0    = '{out_byte: CH_CR, end_of_message: 1'b0,
                                     format_error: 1'b0};
                end else if (!is_lf && !is_cr && !cur_ext && is_hex && size_ovf) begin
                    o_push.count = 2'd1;
                    o_push.r0    = '{out_byte: 8'h00, end_of_message: 1'b1,
                                     format_error: 1'b1};
                end
            end
            PH_DATA_CR, PH_DATA_LF: begin
                if ((cur_phase == PH_DATA_CR) ? !is_cr : !is_lf) begin
                    o_push.count = 2'd1;
                    o_push.r0    = '{out_byte: 8'h00, end_of_message: 1'b1,
                                     format_error: 1'b1};
                end
            end
            default: begin
                o_push.count = 2'd0;
            end
        endcase
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_bytes_left <= '0;
            r_line_text  <= 1'b0;
            r_digit_seen <= 1'b0;
            r_in_ext     <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_line_text  <= n_line_text;
            r_digit_seen <= n_digit_seen;
            r_in_ext     <= n_in_ext;
        end
    end

endmodule

@@ design/cbd_out_queue.sv @@
// Small result queue taking up to two items per cycle and giving one per cycle when popped.
module cbd_out_queue import cbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_result   o_head,
    output logic      o_valid,
    output t_q_status o_status
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QLVL_W-1:0] r_level,  n_level;
    logic [QPTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = r_wr_ptr + 1'b1;

    // Pointer and level update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {{(QPTR_W-1){1'b0}}, i_pop};
        n_level  = r_level + {{(QLVL_W-2){1'b0}}, i_push.count}
                           - {{(QLVL_W-1){1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.r1;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_valid        = (r_level != '0);
    assign o_status.level = r_level;
    assign o_status.full2 = (r_level > QLVL_W'(QDEPTH - 2));

endmodule

@@ design/chunked_body_decoder.sv @@
// Top level of the chunked body decoder: parser feeding a result queue.
// Decodes an HTTP request that arrives one byte per item: header bytes pass
// through up to the blank line, then chunk-size lines are parsed as hex and
// exactly that many data bytes pass, with the CRLF after each chunk checked
// and dropped. A zero-size line yields a closing CR and LF, the LF marked as
// end of message; a malformed body yields one error item and then silence
// until an item with first_byte set. Every input item is processed in the
// cycle it is accepted, so it takes one byte per clock unless the input is
// stalled. Results go through a four-entry queue; the output gives one item
// per clock while items are queued and the output is not stalled, and the
// zero size line is the only input that makes two items. The input stalls
// only while fewer than two queue entries are free, which happens only when
// the output side is stalled. Results are registered in the queue entries.
module chunked_body_decoder import cbd_pkg::*; #(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_first_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_message,
    output logic       o_format_error
);

    logic      in_accept;
    logic      out_pop;
    t_push     push;
    t_result   head;
    t_q_status q_status;

    // Handshakes.
    assign o_in_stall = q_status.full2;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_pop    = o_out_valid && !i_out_stall;

    cbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_in_byte    (i_in_byte),
        .i_first_byte (i_first_byte),
        .o_push       (push)
    );

    cbd_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (out_pop),
        .o_head   (head),
        .o_valid  (o_out_valid),
        .o_status (q_status)
    );

    assign o_out_byte       = head.out_byte;
    assign o_end_of_message = head.end_of_message;
    assign o_format_error   = head.format_error;

    // The queue never holds more items than it has entries.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= QLVL_W'(QDEPTH))
        else $error("result queue overflow");

    // An error item always carries a zero byte and the end mark.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_format_error) |-> (o_end_of_message && o_out_byte == 8'h00))
        else $error("malformed error item");

    // A double push is always the closing CR then the marked LF.
    a_close_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (push.r0.out_byte == CH_CR && push.r1.end_of_message
                                  && push.r1.out_byte == CH_LF))
        else $error("bad closing pair");

endmodule

@@ dv/tb_chunked_body_decoder.sv @@
// Self-checking testbench for the chunked body decoder with directed and random requests.
module tb_chunked_body_decoder;
    import cbd_pkg::*;

    localparam int SZ = SIZE_BITS_DEF;
    localparam int N_DIRECTED = 24;
    localparam int N_PARSED_TARGET = 1850;

    // One input item together with an optional hand-written expectation.
    typedef struct packed {
        logic [7:0] b;
        logic       restart;
        logic       typed;
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } req_byte_t;

    // Shapes of randomly generated requests.
    typedef enum int {
        REQ_GOOD,
        REQ_EMPTY_SIZE,
        REQ_OVERFLOW,
        REQ_BAD_CRLF,
        REQ_TRUNCATED,
        REQ_NOISE
    } req_shape_t;

    localparam t_result NO_RESULT = '0;
    localparam t_result ERROR_RESULT = '{8'h00, 1'b1, 1'b1};

    // Directed requests: a normal one ending in a zero-size line, one with an
    // empty size line, and one with a missing CR after the chunk data.
    localparam req_byte_t DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b0}, NO_RESULT},
        '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0, 1'b0}, NO_RESULT},
        '{CH_LF, 1'b0, 1'b1, 2'd1, '{CH_LF, 1'b0, 1'b0}, NO_RESULT},
        '{CH_CR, 1'b0, 1'b1, 2'd1, '{CH_CR, 1'b0, 1'b0}, NO_RESULT},
        // A line holding only a CR ends the header.
        '{CH_LF, 1'b0, 1'b1, 2'd1, '{CH_LF, 1'b0, 1'b0}, NO_RESULT},
        '{"1",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_CR, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{";",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"a",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LF, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_CR, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_CR, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LF, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        // Zero size closes the body with CR and a marked LF.
        '{CH_LF, 1'b0, 1'b1, 2'd2, '{CH_CR, 1'b0, 1'b0}, '{CH_LF, 1'b1, 1'b0}},
        '{"Q",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LF, 1'b1, 1'b1, 2'd1, '{CH_LF, 1'b0, 1'b0}, NO_RESULT},
        '{CH_LF, 1'b0, 1'b1, 2'd1, ERROR_RESULT, NO_RESULT},
        '{"5",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LF, 1'b1, 1'b1, 2'd1, '{CH_LF, 1'b0, 1'b0}, NO_RESULT},
        '{"1",   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LF, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'h41, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LF, 1'b0, 1'b1, 2'd1, ERROR_RESULT, NO_RESULT}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_first_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_end_of_message;
    logic       o_format_error;

    // Parser state of the predictor.
    t_phase        dec_phase = PH_HEADER;
    logic [SZ-1:0] dec_left = '0;
    logic          dec_text = 1'b0;
    logic          dec_digit = 1'b0;
    logic          dec_ext = 1'b0;

    t_result   awaited_bytes [$];
    req_byte_t cur_item = '0;
    logic      start_pending = 1'b0;
    int        parsed_items = 0;
    int        mismatches = 0;
    logic      calm;

    chunked_body_decoder #(.SIZE_BITS(SZ)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .i_first_byte     (i_first_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_end_of_message (o_end_of_message),
        .o_format_error   (o_format_error)
    );

    always #10 i_clk = ~i_clk;

    // Both sides run without gaps for a stretch in the middle of the random part.
    assign calm = (parsed_items >= 700) && (parsed_items < 1000);

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    function automatic void restart_parser();
        dec_phase = PH_HEADER;
        dec_left = '0;
        dec_text = 1'b0;
        dec_digit = 1'b0;
        dec_ext = 1'b0;
    endfunction

    function automatic void open_size_line();
        dec_phase = PH_SIZE;
        dec_left = '0;
        dec_digit = 1'b0;
        dec_ext = 1'b0;
    endfunction

    // Advances the predicted parser by one byte and returns the decoded items.
    function automatic void decode_step(input logic [7:0] c, input logic restart,
                                        output int n, output t_result r0,
                                        output t_result r1);
        logic [4:0] dv;
        n = 0;
        r0 = NO_RESULT;
        r1 = NO_RESULT;
        if (restart) begin
            restart_parser();
        end
        case (dec_phase)
            PH_HEADER: begin
                n = 1;
                r0 = '{c, 1'b0, 1'b0};
                if (c == CH_LF) begin
                    if (!dec_text) begin
                        open_size_line();
                    end
                    dec_text = 1'b0;
                end else if (c != CH_CR) begin
                    dec_text = 1'b1;
                end
            end
            PH_SIZE: begin
                if (c == CH_LF) begin
                    if (!dec_digit) begin
                        n = 1;
                        r0 = ERROR_RESULT;
                        dec_phase = PH_ERROR;
                    end else if (dec_left == '0) begin
                        n = 2;
                        r0 = '{CH_CR, 1'b0, 1'b0};
                        r1 = '{CH_LF, 1'b1, 1'b0};
                        dec_phase = PH_DONE;
                    end else begin
                        dec_phase = PH_DATA;
                    end
                end else if (c != CH_CR && !dec_ext) begin
                    // Classify the character as a hex digit or the start of an extension.
                    if (c >= "0" && c <= "9") begin
                        dv = {1'b0, c[3:0]};
                    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                        dv = {1'b0, c[3:0] + 4'd9};
                    end else begin
                        dv = 5'h10;
                    end
                    if (dv[4]) begin
                        dec_ext = 1'b1;
                    end else if (dec_left[SZ-1 -: 4] != 4'h0) begin
                        n = 1;
                        r0 = ERROR_RESULT;
                        dec_phase = PH_ERROR;
                    end else begin
                        dec_left = {dec_left[SZ-5:0], dv[3:0]};
                        dec_digit = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                n = 1;
                r0 = '{c, 1'b0, 1'b0};
                dec_left = dec_left - 1'b1;
                if (dec_left == '0) begin
                    dec_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (c != CH_CR) begin
                    n = 1;
                    r0 = ERROR_RESULT;
                    dec_phase = PH_ERROR;
                end else begin
                    dec_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (c != CH_LF) begin
                    n = 1;
                    r0 = ERROR_RESULT;
                    dec_phase = PH_ERROR;
                end else begin
                    open_size_line();
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Predict on every accepted input item and check every accepted output item.
    always @(posedge i_clk) begin : check_out
        int      n;
        t_result p0;
        t_result p1;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            restart_parser();
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_first_byte || (dec_phase != PH_DONE && dec_phase != PH_ERROR)) begin
                    parsed_items++;
                end
                decode_step(i_in_byte, i_first_byte, n, p0, p1);
                if (cur_item.typed) begin
                    n = cur_item.n;
                    p0 = cur_item.r0;
                    p1 = cur_item.r1;
                end
                if (n > 0) begin
                    awaited_bytes.push_back(p0);
                end
                if (n > 1) begin
                    awaited_bytes.push_back(p1);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_byte, o_end_of_message, o_format_error};
                if (awaited_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item, expected none, got byte %02h eom %b err %b",
                             $time, got.out_byte, got.end_of_message, got.format_error);
                end else begin
                    want = awaited_bytes.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.out_byte, got.out_byte);
                    end
                    if (got.end_of_message !== want.end_of_message) begin
                        mismatches++;
                        $display("%0t: end_of_message expected %b, got %b",
                                 $time, want.end_of_message, got.end_of_message);
                    end
                    if (got.format_error !== want.format_error) begin
                        mismatches++;
                        $display("%0t: format_error expected %b, got %b",
                                 $time, want.format_error, got.format_error);
                    end
                end
            end
        end
    end

    // Drives one item from a falling edge and returns at the falling edge after acceptance.
    task automatic drive_item(input req_byte_t item);
        while (!calm && $urandom_range(0, 99) < 26) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte = item.b;
        i_first_byte = item.restart;
        cur_item = item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Sends one random-part byte; the first byte of a request carries the restart flag.
    task automatic send_byte(input logic [7:0] b);
        req_byte_t item;
        item = '0;
        item.b = b;
        item.restart = start_pending;
        start_pending = 1'b0;
        drive_item(item);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'("0") + {4'h0, v};
        end
        return (($urandom_range(0, 1) == 1) ? 8'("A") : 8'("a")) + {4'h0, v} - 8'd10;
    endfunction

    // Any byte but LF, for header text and size-line extensions.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF) begin
            b = "h";
        end
        return b;
    endfunction

    // Generates and sends one request; most are well formed, the rest broken or noise.
    task automatic random_request();
        int          pick;
        req_shape_t  shape;
        int          nchunks;
        int          brk_at;
        int          ndig;
        logic [31:0] sz;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            shape = REQ_GOOD;
        end else if (pick < 78) begin
            shape = REQ_EMPTY_SIZE;
        end else if (pick < 84) begin
            shape = REQ_OVERFLOW;
        end else if (pick < 91) begin
            shape = REQ_BAD_CRLF;
        end else if (pick < 96) begin
            shape = REQ_TRUNCATED;
        end else begin
            shape = REQ_NOISE;
        end
        start_pending = 1'b1;

        // Raw bytes with scattered restarts, possibly landing in any parser phase.
        if (shape == REQ_NOISE) begin
            start_pending = ($urandom_range(0, 1) == 1);
            repeat ($urandom_range(1, 16)) begin
                send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0) begin
                    start_pending = 1'b1;
                end
            end
            return;
        end

        // Header lines, then the blank line made of zero to two CRs and an LF.
        repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(text_byte());
            end
            if ($urandom_range(0, 3) != 0) begin
                send_byte(CH_CR);
            end
            send_byte(CH_LF);
        end
        repeat ($urandom_range(0, 2)) begin
            send_byte(CH_CR);
        end
        send_byte(CH_LF);

        if (shape == REQ_TRUNCATED) begin
            repeat ($urandom_range(0, 4)) begin
                send_byte(hex_char(4'($urandom_range(0, 15))));
            end
            return;
        end

        nchunks = $urandom_range((shape == REQ_BAD_CRLF) ? 1 : 0, 3);
        brk_at = $urandom_range(0, nchunks - ((shape == REQ_BAD_CRLF) ? 1 : 0));
        for (int k = 0; k <= nchunks; k++) begin
            if (shape == REQ_EMPTY_SIZE && k == brk_at) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(";");
                end
                send_byte(CH_CR);
                send_byte(CH_LF);
                return;
            end
            // Nine or more significant digits overflow the size counter.
            if (shape == REQ_OVERFLOW && k == brk_at) begin
                send_byte(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 10)) begin
                    send_byte(hex_char(4'($urandom_range(0, 15))));
                end
                send_byte(CH_CR);
                send_byte(CH_LF);
                return;
            end

            // Size line: optional leading zeros, digits in mixed case, optional extension.
            if (k == nchunks) begin
                sz = 32'd0;
            end else if ($urandom_range(0, 9) == 0) begin
                sz = $urandom_range(13, 60);
            end else begin
                sz = $urandom_range(1, 12);
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte("0");
                end
            end
            ndig = 1;
            while (ndig < 8 && (sz >> (4 * ndig)) != 0) begin
                ndig++;
            end
            for (int d = ndig - 1; d >= 0; d--) begin
                send_byte(hex_char(sz[4 * d +: 4]));
            end
            if ($urandom_range(0, 3) == 0) begin
                send_byte(";");
                repeat ($urandom_range(0, 5)) begin
                    send_byte(text_byte());
                end
            end
            if ($urandom_range(0, 7) != 0) begin
                send_byte(CH_CR);
            end
            send_byte(CH_LF);

            if (k == nchunks) begin
                // Trailing bytes after the end are dropped by the block.
                repeat ($urandom_range(0, 2)) begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                repeat (sz) begin
                    send_byte(8'($urandom_range(0, 255)));
                end
                if (shape == REQ_BAD_CRLF && k == brk_at) begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte(CH_CR);
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_LF) begin
                            b = "L";
                        end
                    end else begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_CR) begin
                            b = "C";
                        end
                    end
                    send_byte(b);
                    repeat ($urandom_range(0, 3)) begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                    return;
                end
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
        end
    endtask

    // Reset, directed table, random requests, then drain and report.
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            drive_item(DIRECTED[i]);
        end
        while (parsed_items < N_PARSED_TARGET) begin
            random_request();
        end
        i_in_valid = 1'b0;
        while (awaited_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
